@@ hdl/dclcd_pkg.sv @@
// Shared constants for the dual-chip graphic LCD column controller.
package dclcd_pkg;

	localparam int DEF_NUM_CHIPS   = 2;
	localparam int DEF_NUM_COLUMNS = 64;
	localparam int DEF_NUM_PAGES   = 8;

	// Control byte decode: mask and match for each command
	localparam logic [7:0] CMD_ON_MASK   = 8'b11111110;
	localparam logic [7:0] CMD_ON_MATCH  = 8'b00111110;
	localparam logic [7:0] CMD_COL_MASK  = 8'b11000000;
	localparam logic [7:0] CMD_COL_MATCH = 8'b01000000;
	localparam logic [7:0] CMD_PG_MASK   = 8'b11111000;
	localparam logic [7:0] CMD_PG_MATCH  = 8'b10111000;
	localparam logic [7:0] CMD_SL_MASK   = 8'b11000000;
	localparam logic [7:0] CMD_SL_MATCH  = 8'b11000000;

	localparam logic [7:0] STATUS_OFF = 8'b00100000;
	localparam logic [7:0] STATUS_ON  = 8'b00000000;

	// Access encodings on the bus
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;
	localparam logic REG_CTRL  = 1'b0;
	localparam logic REG_DATA  = 1'b1;

endpackage

@@ hdl/dclcd_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module dclcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ hdl/dual_chip_graphic_lcd_controller_core.sv @@
// Dual-chip graphic LCD column controller: bus accesses against per-chip display memory.
// Throughput: one transaction per cycle while in_stall is low; a read result is registered at acceptance.
// Writes give no result. Data reads return the output latch, which is refilled from the
// display memory (registered read port, forwarded to a back-to-back read of the same chip).
// After reset the memory is cleared, one byte a cycle, over all NUM_CHIPS*NUM_PAGES*NUM_COLUMNS
// bytes (1024 by default); in_stall is held high during that pass.
module dual_chip_graphic_lcd_controller_core
	import dclcd_pkg::*;
#(
	parameter int NUM_CHIPS   = DEF_NUM_CHIPS,
	parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
	parameter int NUM_PAGES   = DEF_NUM_PAGES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic       chip_sel,
	input  logic       reg_sel,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);

	localparam int DEPTH  = NUM_CHIPS * NUM_PAGES * NUM_COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
	localparam int COL_W  = $clog2(NUM_COLUMNS);
	localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

	logic [PAGE_W-1:0] page_q  [NUM_CHIPS];
	logic [COL_W-1:0]  col_q   [NUM_CHIPS];
	logic              on_q    [NUM_CHIPS];
	logic [7:0]        latch_q [NUM_CHIPS];

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              pend_q;
	logic [CHIP_W-1:0] pend_chip_q;
	logic              out_valid_q;
	logic [7:0]        read_data_q;

	logic              accept;
	logic              chip_ok;
	logic [CHIP_W-1:0] chip_idx;
	logic [PAGE_W-1:0] page_cur;
	logic [COL_W-1:0]  col_cur;
	logic [COL_W-1:0]  col_next;
	logic [ADDR_W-1:0] cell_addr;
	logic [7:0]        latch_eff;
	logic [7:0]        result;
	logic              data_acc;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	// Wrap tables for column and page values taken from command bytes
	logic [COL_W-1:0]  col_mod  [64];
	logic [PAGE_W-1:0] page_mod [8];

	for (genvar g = 0; g < 64; g++) begin : g_col_mod
		assign col_mod[g] = COL_W'(g % NUM_COLUMNS);
	end
	for (genvar g = 0; g < 8; g++) begin : g_page_mod
		assign page_mod[g] = PAGE_W'(g % NUM_PAGES);
	end

	assign in_stall  = clr_busy_q | (out_valid_q & out_stall);
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	assign chip_ok  = int'(chip_sel) < NUM_CHIPS;
	assign chip_idx = chip_ok ? CHIP_W'(chip_sel) : '0;
	assign page_cur = page_q[chip_idx];
	assign col_cur  = col_q[chip_idx];
	assign col_next = (col_cur == COL_W'(NUM_COLUMNS - 1)) ? '0 : col_cur + 1'b1;
	assign cell_addr = ADDR_W'((int'(chip_idx) * NUM_PAGES + int'(page_cur)) * NUM_COLUMNS
		+ int'(col_cur));

	// Forward the memory byte still on its way into the latch
	assign latch_eff = (pend_q && pend_chip_q == chip_idx) ? ram_rdata : latch_q[chip_idx];

	always_comb begin
		if (!chip_ok) begin
			result = '0;
		end else if (reg_sel == REG_DATA) begin
			result = latch_eff;
		end else begin
			result = on_q[chip_idx] ? STATUS_ON : STATUS_OFF;
		end
	end

	assign data_acc = accept & chip_ok & (reg_sel == REG_DATA);

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = data_acc & (req_type == REQ_WRITE);
			ram_addr  = cell_addr;
			ram_wdata = write_data;
		end
	end

	dclcd_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && req_type == REQ_READ) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_READ) begin
			read_data_q <= result;
		end
	end

	// Per-chip registers; the start line only drives panel scanning, so its command is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHIPS; i++) begin
				page_q[i]  <= '0;
				col_q[i]   <= '0;
				on_q[i]    <= 1'b0;
				latch_q[i] <= '0;
			end
			pend_q      <= 1'b0;
			pend_chip_q <= '0;
		end else begin
			if (pend_q) begin
				latch_q[pend_chip_q] <= ram_rdata;
			end
			pend_q      <= data_acc & (req_type == REQ_READ);
			pend_chip_q <= chip_idx;
			if (data_acc) begin
				col_q[chip_idx] <= col_next;
			end else if (accept && chip_ok && req_type == REQ_WRITE) begin
				if ((write_data & CMD_ON_MASK) == CMD_ON_MATCH) begin
					on_q[chip_idx] <= write_data[0];
				end else if ((write_data & CMD_COL_MASK) == CMD_COL_MATCH) begin
					col_q[chip_idx] <= col_mod[write_data[5:0]];
				end else if ((write_data & CMD_PG_MASK) == CMD_PG_MATCH) begin
					page_q[chip_idx] <= page_mod[write_data[2:0]];
				end
			end
		end
	end

endmodule

@@ hdl/dclcd_checker.sv @@
// Port-level checker for the LCD controller core, bound to the top level.
module dclcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       req_type,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data
);

	logic in_acc;
	assign in_acc = in_valid & ~in_stall;

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type |=> out_valid)
		else $error("read transaction produced no result");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !req_type |=> !$rose(out_valid))
		else $error("write transaction produced a result");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc && req_type))
		else $error("result without a read transaction");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("stalled result changed");

endmodule

bind dual_chip_graphic_lcd_controller_core dclcd_checker u_dclcd_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the dual-chip graphic LCD column controller core.
module testbench;
	import dclcd_pkg::*;

	typedef struct {
		logic        req;
		logic        chip;
		logic        regsel;
		logic [7:0]  wbyte;
		int unsigned gap;
		bit          wait_empty;
	} bus_access_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       req_type = 1'b0;
	logic       chip_sel = 1'b0;
	logic       reg_sel = 1'b0;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;

	dual_chip_graphic_lcd_controller_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.chip_sel   (chip_sel),
		.reg_sel    (reg_sel),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

	always #5 clk = ~clk;

	// Mirror of both chips' state
	logic [7:0] mir_pix [1024];
	logic [2:0] mir_page [2];
	logic [5:0] mir_col [2];
	logic [5:0] mir_start [2];
	logic       mir_on [2];
	logic [7:0] mir_latch [2];

	bus_access_t bus_accesses[$];
	logic [7:0]  read_bytes_due[$];
	int          mismatches = 0;
	int          accesses_queued = 0;
	bit          burst_mode = 0;
	bit          drain_next = 0;

	task automatic queue_access(input logic rd, input logic chip, input logic regsel,
			input logic [7:0] b);
		bus_access_t a;
		a.req = rd;
		a.chip = chip;
		a.regsel = regsel;
		a.wbyte = b;
		a.gap = burst_mode ? 0 : $urandom_range(0, 11);
		a.wait_empty = drain_next;
		drain_next = 0;
		bus_accesses.push_back(a);
		accesses_queued++;
	endtask

	task automatic lcd_mirror_step(input bus_access_t a);
		logic [9:0] addr;
		addr = {a.chip, mir_page[a.chip], mir_col[a.chip]};
		if (a.req == REQ_WRITE) begin
			if (a.regsel == REG_DATA) begin
				mir_pix[addr] = a.wbyte;
				mir_col[a.chip] = mir_col[a.chip] + 6'd1;
			end else if ((a.wbyte & CMD_ON_MASK) == CMD_ON_MATCH) begin
				mir_on[a.chip] = a.wbyte[0];
			end else if ((a.wbyte & CMD_COL_MASK) == CMD_COL_MATCH) begin
				mir_col[a.chip] = a.wbyte[5:0];
			end else if ((a.wbyte & CMD_PG_MASK) == CMD_PG_MATCH) begin
				mir_page[a.chip] = a.wbyte[2:0];
			end else if ((a.wbyte & CMD_SL_MASK) == CMD_SL_MATCH) begin
				mir_start[a.chip] = a.wbyte[5:0];
			end
		end else if (a.regsel == REG_DATA) begin
			// dummy-read behaviour: hand out the latch, then refill it
			read_bytes_due.push_back(mir_latch[a.chip]);
			mir_latch[a.chip] = mir_pix[addr];
			mir_col[a.chip] = mir_col[a.chip] + 6'd1;
		end else begin
			read_bytes_due.push_back(mir_on[a.chip] ? STATUS_ON : STATUS_OFF);
		end
	endtask

	// Driver
	bus_access_t cur;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= 1'b0;
			chip_sel <= 1'b0;
			reg_sel <= 1'b0;
			write_data <= 8'h00;
			gap_left = bus_accesses.size() > 0 ? bus_accesses[0].gap : 0;
		end else begin
			if (in_valid && !in_stall) begin
				lcd_mirror_step(cur);
				gap_left = bus_accesses.size() > 0 ? bus_accesses[0].gap : 0;
			end
			if ((in_valid && !in_stall) || !in_valid) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (bus_accesses.size() > 0 &&
						(!bus_accesses[0].wait_empty || read_bytes_due.size() == 0)) begin
					cur = bus_accesses.pop_front();
					in_valid <= 1'b1;
					req_type <= cur.req;
					chip_sel <= cur.chip;
					reg_sel <= cur.regsel;
					write_data <= cur.wbyte;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stalls
	int          results_seen = 0;
	int unsigned hold_cnt = 0;
	bit          rx_fast = 0;
	logic [7:0]  due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (read_bytes_due.size() == 0) begin
					$error("read_data: expected nothing, actual %02h", read_data);
					mismatches++;
				end else begin
					due = read_bytes_due.pop_front();
					if (read_data !== due) begin
						$error("read_data: expected %02h, actual %02h", due, read_data);
						mismatches++;
					end
				end
				results_seen++;
				if (results_seen % 50 == 0)
					rx_fast = ($urandom_range(0, 3) == 0);
				// hold off long enough for the core to back up into its input
				if (results_seen == 120)
					hold_cnt = 300;
				else
					hold_cnt = rx_fast ? 0 : $urandom_range(0, 11);
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end
			out_stall <= (hold_cnt != 0);
		end
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic       c;
		logic [5:0] col;
		int         n;
		int         pick;

		foreach (mir_pix[i])
			mir_pix[i] = 8'h00;
		for (int i = 0; i < 2; i++) begin
			mir_page[i] = '0;
			mir_col[i] = '0;
			mir_start[i] = '0;
			mir_on[i] = 1'b0;
			mir_latch[i] = '0;
		end

		// Directed: status both ways, column wrap, dummy read, ignored bytes, chip split
		queue_access(REQ_READ, 1'b0, REG_CTRL, 8'h00);
		queue_access(REQ_READ, 1'b1, REG_CTRL, 8'hFF);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, CMD_ON_MATCH | 8'h01);
		queue_access(REQ_READ, 1'b0, REG_CTRL, 8'h00);
		queue_access(REQ_WRITE, 1'b1, REG_CTRL, CMD_ON_MATCH);
		queue_access(REQ_READ, 1'b1, REG_CTRL, 8'h55);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, CMD_PG_MATCH | 8'h07);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, CMD_COL_MATCH | 8'h3F);
		queue_access(REQ_WRITE, 1'b0, REG_DATA, 8'hFF);
		queue_access(REQ_WRITE, 1'b0, REG_DATA, 8'h00);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, CMD_COL_MATCH | 8'h3F);
		repeat (3) queue_access(REQ_READ, 1'b0, REG_DATA, 8'hAA);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, 8'h00);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, 8'h3D);
		queue_access(REQ_WRITE, 1'b1, REG_CTRL, 8'hB7);
		queue_access(REQ_WRITE, 1'b1, REG_CTRL, 8'h80);
		queue_access(REQ_WRITE, 1'b1, REG_CTRL, CMD_SL_MATCH | 8'h3F);
		queue_access(REQ_WRITE, 1'b0, REG_CTRL, CMD_SL_MATCH);
		queue_access(REQ_WRITE, 1'b1, REG_DATA, 8'h5A);
		queue_access(REQ_WRITE, 1'b1, REG_CTRL, CMD_COL_MATCH);
		queue_access(REQ_READ, 1'b1, REG_DATA, 8'h00);
		queue_access(REQ_READ, 1'b1, REG_DATA, 8'hFF);
		queue_access(REQ_READ, 1'b0, REG_CTRL, 8'hFF);

		// Random: mostly write-then-read-back runs, the rest noise
		while (accesses_queued < 925) begin
			if ($urandom_range(0, 39) == 0)
				burst_mode = ~burst_mode;
			if (accesses_queued > 460 && accesses_queued < 470)
				drain_next = 1;
			c = $urandom_range(0, 1);
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				col = $urandom_range(0, 63);
				n = $urandom_range(1, 8);
				queue_access(REQ_WRITE, c, REG_CTRL, CMD_PG_MATCH | 8'($urandom_range(0, 7)));
				queue_access(REQ_WRITE, c, REG_CTRL, CMD_COL_MATCH | {2'b00, col});
				repeat (n) queue_access(REQ_WRITE, c, REG_DATA, 8'($urandom));
				queue_access(REQ_WRITE, c, REG_CTRL, CMD_COL_MATCH | {2'b00, col});
				repeat (n + 1) queue_access(REQ_READ, c, REG_DATA, 8'($urandom));
			end else if (pick == 6) begin
				queue_access(REQ_WRITE, c, REG_CTRL, CMD_ON_MATCH | 8'($urandom_range(0, 1)));
				queue_access(REQ_READ, c, REG_CTRL, 8'($urandom));
			end else if (pick == 7) begin
				queue_access(REQ_WRITE, c, REG_CTRL, CMD_SL_MATCH | 8'($urandom_range(0, 63)));
			end else if (pick == 8) begin
				queue_access(1'($urandom), c, 1'($urandom), 8'($urandom));
			end else begin
				queue_access(REQ_READ, c, REG_CTRL, 8'($urandom));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (bus_accesses.size() == 0 && !in_valid);
		wait (read_bytes_due.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
